@@ rtl/flpmq_pkg.sv @@
// ----------------------------------------------------------------------------
// flpmq_pkg
// Shared codes and field widths of the four-level priority message queue.
// ----------------------------------------------------------------------------
`default_nettype none
package flpmq_pkg;

  localparam logic [1:0] CMD_ENQ      = 2'd0;
  localparam logic [1:0] CMD_DEQ      = 2'd1;
  localparam logic [1:0] CMD_DEQ_TYPE = 2'd2;
  localparam logic [1:0] CMD_DEQ_RECV = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic [15:0] RECV_BROADCAST = 16'hFFFF;

  localparam int TYPE_BITS = 8;
  localparam int RECV_BITS = 16;

endpackage
`default_nettype wire

@@ rtl/flpmq_store.sv @@
// ----------------------------------------------------------------------------
// flpmq_store
// Entry and link memories, each one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module flpmq_store #(
  parameter int DEPTH = 64,
  parameter int HW    = 32,
  parameter int AW    = 6
) (
  input  wire logic                       clk,
  input  wire logic                       ent_we,
  input  wire logic [AW-1:0]              ent_waddr,
  input  wire logic [HW-1:0]              ent_whandle,
  input  wire logic [flpmq_pkg::TYPE_BITS-1:0] ent_wtype,
  input  wire logic [flpmq_pkg::RECV_BITS-1:0] ent_wrecv,
  input  wire logic [AW-1:0]              ent_raddr,
  output logic [HW-1:0]                   ent_rhandle,
  output logic [flpmq_pkg::TYPE_BITS-1:0] ent_rtype,
  output logic [flpmq_pkg::RECV_BITS-1:0] ent_rrecv,
  input  wire logic                       lnk_we,
  input  wire logic [AW-1:0]              lnk_waddr,
  input  wire logic [AW-1:0]              lnk_wdata,
  input  wire logic [AW-1:0]              lnk_raddr,
  output logic [AW-1:0]                   lnk_rdata
);

  localparam int EW = HW + flpmq_pkg::TYPE_BITS + flpmq_pkg::RECV_BITS;

  logic [EW-1:0] ent_mem [DEPTH];
  logic [AW-1:0] lnk_mem [DEPTH];
  logic [EW-1:0] ent_q;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= {ent_whandle, ent_wtype, ent_wrecv};
    end
    ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    lnk_rdata <= lnk_mem[lnk_raddr];
  end

  assign ent_rhandle = ent_q[EW-1 -: HW];
  assign ent_rtype   = ent_q[flpmq_pkg::RECV_BITS +: flpmq_pkg::TYPE_BITS];
  assign ent_rrecv   = ent_q[flpmq_pkg::RECV_BITS-1:0];

endmodule
`default_nettype wire

@@ rtl/four_level_priority_message_queue_unit.sv @@
// ----------------------------------------------------------------------------
// four_level_priority_message_queue_unit
// Strict-priority message queue with one linked-list entry store shared by all levels.
// ----------------------------------------------------------------------------
// One command is handled at a time.
// - A refused enqueue goes straight on to the head read.
// - An enqueue takes a free entry and writes it; when it is appended behind an
//   entry of the same level, the old tail link needs one more write.
// - A plain dequeue steps down past each empty level above the level it serves.
// - A filtered dequeue also steps past each entry it passes (one read of the
//   entry and link memories each), moves down a level at a time, and patches
//   the predecessor link when it removes an entry from inside a list.
// Finding the head handle costs one more entry-memory read. The result sits in
// an output register, and the next command is taken as soon as that register
// is handed over.
`default_nettype none
module four_level_priority_message_queue_unit #(
  parameter int STORE_DEPTH = 64,
  parameter int LEVELS      = 4,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [HANDLE_BITS-1:0] in_msg_handle,
  input  wire logic [2:0]  in_msg_priority,
  input  wire logic [7:0]  in_msg_type,
  input  wire logic signed [15:0] in_msg_receiver,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [HANDLE_BITS-1:0] out_out_handle,
  output logic [1:0]       out_out_priority,
  output logic [7:0]       out_out_type,
  output logic signed [15:0] out_out_receiver,
  output logic [$clog2(STORE_DEPTH+1)-1:0] out_occupancy,
  output logic             out_at_limit,
  output logic             out_head_valid,
  output logic [HANDLE_BITS-1:0] out_head_handle,
  output logic [31:0]      out_dropped_total,
  output logic [31:0]      out_enqueue_fail_total,
  output logic [31:0]      out_dequeue_fail_total,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEF_LVL = (LEVELS > 2) ? 2 : LEVELS - 1;
  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_DROP  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ENQ_FREE, S_ENQ_WRITE, S_DEQ_READ, S_DEQ_CHECK,
    S_DEQ_UNLINK, S_LINK_PATCH, S_HEAD_READ, S_HEAD_WAIT, S_RESULT
  } state_t;

  state_t state_r;
  logic [6:0] size_limit_r;
  logic drop_r;

  logic [1:0] cmd_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [LW-1:0] lvl_in_r;
  logic [7:0] typ_r;
  logic [15:0] rcv_r;

  logic [AW-1:0] head_r [LEVELS];
  logic [AW-1:0] tail_r [LEVELS];
  logic [CW-1:0] cnt_r [LEVELS];
  logic [CW-1:0] held_r;
  logic [AW-1:0] free_top_r;
  logic [CW-1:0] free_init_r;
  logic [31:0] drop_cnt_r, efail_cnt_r, dfail_cnt_r;

  logic [LW-1:0] lvl_r;
  logic [AW-1:0] cur_r, prev_r, new_e_r;
  logic has_prev_r;
  logic [CW-1:0] k_r;

  logic ent_we, lnk_we;
  logic [AW-1:0] ent_waddr, ent_raddr, lnk_waddr, lnk_wdata, lnk_raddr, lnk_rdata;
  logic [HANDLE_BITS-1:0] ent_rhandle;
  logic [7:0] ent_rtype;
  logic [15:0] ent_rrecv;

  flpmq_store #(.DEPTH(STORE_DEPTH), .HW(HANDLE_BITS), .AW(AW)) u_store (
    .clk(clk), .ent_we(ent_we), .ent_waddr(ent_waddr), .ent_whandle(hnd_r),
    .ent_wtype(typ_r), .ent_wrecv(rcv_r), .ent_raddr(ent_raddr),
    .ent_rhandle(ent_rhandle), .ent_rtype(ent_rtype), .ent_rrecv(ent_rrecv),
    .lnk_we(lnk_we), .lnk_waddr(lnk_waddr), .lnk_wdata(lnk_wdata),
    .lnk_raddr(lnk_raddr), .lnk_rdata(lnk_rdata)
  );

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      ADDR_LIMIT: prdata = {25'd0, size_limit_r};
      ADDR_DROP:  prdata = {31'd0, drop_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Highest non-empty level, and whether any exists.
  logic any_held;
  logic [LW-1:0] top_lvl;
  always_comb begin
    any_held = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        any_held = 1'b1;
        top_lvl = LW'(l);
      end
    end
  end

  logic match;
  always_comb begin
    case (cmd_r)
      flpmq_pkg::CMD_DEQ_TYPE: match = (ent_rtype == typ_r);
      flpmq_pkg::CMD_DEQ_RECV: match = (ent_rrecv == rcv_r) ||
                                       (ent_rrecv == flpmq_pkg::RECV_BROADCAST);
      default:                 match = 1'b1;
    endcase
  end

  logic limit_hit;
  assign limit_hit = (size_limit_r != 7'd0) && ({25'd0, size_limit_r} <= 32'(held_r));

  // Memory port control follows the state directly.
  always_comb begin
    ent_we = 1'b0; lnk_we = 1'b0;
    ent_waddr = new_e_r; lnk_waddr = new_e_r; lnk_wdata = '0;
    ent_raddr = cur_r; lnk_raddr = cur_r;
    case (state_r)
      S_ENQ_FREE: lnk_raddr = free_top_r;
      S_ENQ_WRITE: begin
        ent_we = 1'b1;
        lnk_we = 1'b1;
      end
      S_DEQ_UNLINK: begin
        lnk_we = 1'b1;
        lnk_waddr = cur_r;
        lnk_wdata = free_top_r;
      end
      S_LINK_PATCH: begin
        lnk_we = 1'b1;
        lnk_waddr = pend_addr_r;
        lnk_wdata = pend_data_r;
      end
      S_HEAD_READ: ent_raddr = head_r[top_lvl];
      default: ;
    endcase
  end

  // The old tail link of an enqueue and the predecessor link of an unlink are
  // written in the patch cycle, after the first link write of the command.
  logic reuse_r;
  logic [AW-1:0] pend_addr_r, pend_data_r;
  logic [AW-1:0] nx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_limit_r <= '0;
      drop_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0; tail_r[l] <= '0; cnt_r[l] <= '0;
      end
      held_r <= '0;
      free_top_r <= '0;
      free_init_r <= '0;
      drop_cnt_r <= '0; efail_cnt_r <= '0; dfail_cnt_r <= '0;
      out_valid <= 1'b0;
      reuse_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr == ADDR_LIMIT) size_limit_r <= pwdata[6:0];
        if (paddr == ADDR_DROP) drop_r <= pwdata[0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_cmd;
            hnd_r <= in_msg_handle;
            typ_r <= in_msg_type;
            rcv_r <= in_msg_receiver;
            lvl_in_r <= (32'(in_msg_priority) >= LEVELS) ? LW'(DEF_LVL)
                                                         : LW'(in_msg_priority);
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          out_out_handle <= '0; out_out_priority <= '0;
          out_out_type <= '0; out_out_receiver <= '0;
          if (cmd_r == flpmq_pkg::CMD_ENQ) begin
            if (hnd_r == '0) begin
              out_status <= flpmq_pkg::ST_REFUSED;
              efail_cnt_r <= efail_cnt_r + 32'd1;
              state_r <= S_HEAD_READ;
            end else if (limit_hit) begin
              if (drop_r) begin
                out_status <= flpmq_pkg::ST_DROPPED;
                drop_cnt_r <= drop_cnt_r + 32'd1;
              end else begin
                out_status <= flpmq_pkg::ST_REFUSED;
                efail_cnt_r <= efail_cnt_r + 32'd1;
              end
              state_r <= S_HEAD_READ;
            end else if (32'(held_r) >= STORE_DEPTH) begin
              out_status <= flpmq_pkg::ST_REFUSED;
              efail_cnt_r <= efail_cnt_r + 32'd1;
              state_r <= S_HEAD_READ;
            end else begin
              out_status <= flpmq_pkg::ST_DONE;
              state_r <= S_ENQ_FREE;
            end
          end else begin
            out_status <= flpmq_pkg::ST_DONE;
            lvl_r <= LW'(LEVELS - 1);
            cur_r <= head_r[LEVELS-1];
            has_prev_r <= 1'b0;
            k_r <= '0;
            state_r <= S_DEQ_READ;
          end
        end
        S_ENQ_FREE: begin
          // Link read of the free list top is issued here; used next cycle.
          if (free_init_r > held_r) begin
            new_e_r <= free_top_r;
            reuse_r <= 1'b1;
          end else begin
            new_e_r <= free_init_r[AW-1:0];
            free_init_r <= free_init_r + CW'(1);
            reuse_r <= 1'b0;
          end
          state_r <= S_ENQ_WRITE;
        end
        S_ENQ_WRITE: begin
          if (reuse_r) free_top_r <= lnk_rdata;
          // Link of new entry is cleared by this write; the old tail is
          // patched in the next cycle.
          if (cnt_r[lvl_in_r] == '0) begin
            head_r[lvl_in_r] <= new_e_r;
            state_r <= S_HEAD_READ;
          end else begin
            pend_addr_r <= tail_r[lvl_in_r];
            pend_data_r <= new_e_r;
            state_r <= S_LINK_PATCH;
          end
          tail_r[lvl_in_r] <= new_e_r;
          cnt_r[lvl_in_r] <= cnt_r[lvl_in_r] + CW'(1);
          held_r <= held_r + CW'(1);
        end
        S_DEQ_READ: begin
          if (k_r >= cnt_r[lvl_r]) begin
            if (lvl_r == '0) begin
              out_status <= flpmq_pkg::ST_EMPTY;
              if (cmd_r == flpmq_pkg::CMD_DEQ) dfail_cnt_r <= dfail_cnt_r + 32'd1;
              state_r <= S_HEAD_READ;
            end else begin
              lvl_r <= lvl_r - LW'(1);
              cur_r <= head_r[lvl_r - LW'(1)];
              has_prev_r <= 1'b0;
              k_r <= '0;
            end
          end else begin
            state_r <= S_DEQ_CHECK;
          end
        end
        S_DEQ_CHECK: begin
          if (match) begin
            nx_r <= lnk_rdata;
            out_out_handle <= ent_rhandle;
            out_out_priority <= 2'(lvl_r);
            out_out_type <= ent_rtype;
            out_out_receiver <= ent_rrecv;
            state_r <= S_DEQ_UNLINK;
          end else begin
            prev_r <= cur_r;
            has_prev_r <= 1'b1;
            cur_r <= lnk_rdata;
            k_r <= k_r + CW'(1);
            state_r <= S_DEQ_READ;
          end
        end
        S_DEQ_UNLINK: begin
          if (!has_prev_r) begin
            head_r[lvl_r] <= nx_r;
            state_r <= S_HEAD_READ;
          end else begin
            pend_addr_r <= prev_r;
            pend_data_r <= nx_r;
            if (cur_r == tail_r[lvl_r]) tail_r[lvl_r] <= prev_r;
            state_r <= S_LINK_PATCH;
          end
          cnt_r[lvl_r] <= cnt_r[lvl_r] - CW'(1);
          held_r <= held_r - CW'(1);
          free_top_r <= cur_r;
        end
        S_LINK_PATCH: state_r <= S_HEAD_READ;
        S_HEAD_READ: state_r <= S_HEAD_WAIT;
        S_HEAD_WAIT: begin
          out_occupancy <= held_r;
          out_at_limit <= limit_hit;
          out_head_valid <= any_held;
          out_head_handle <= any_held ? ent_rhandle : '0;
          out_dropped_total <= drop_cnt_r;
          out_enqueue_fail_total <= efail_cnt_r;
          out_dequeue_fail_total <= dfail_cnt_r;
          out_valid <= 1'b1;
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= STORE_DEPTH) else $error("occupancy above store depth");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result without work");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) |-> out_valid || $past(out_ready))
    else $error("result lost");
`endif

endmodule
`default_nettype wire

@@ tb/tb_four_level_priority_message_queue_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_priority_message_queue_unit
// Self-checking regression of the four-level priority message queue. A
// directed sequence covers empty dequeues, null handles, field extremes,
// priority folding, broadcast matching and the occupancy limit. Random
// traffic then runs under several limit and drop settings. Each result
// transfer is checked against a predicted queue state.
// ----------------------------------------------------------------------------
module tb_four_level_priority_message_queue_unit;

  localparam int DEPTH = 64;
  localparam int NLVL = 4;
  localparam logic [2:0] ADDR_SIZE_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_DROP_MODE = 3'd4;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 80;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle;
    logic [1:0]  level;
    logic [7:0]  typ;
    logic [15:0] recv;
    logic [6:0]  occupancy;
    logic        at_limit;
    logic        head_valid;
    logic [31:0] head_handle;
    logic [31:0] dropped;
    logic [31:0] enq_fail;
    logic [31:0] deq_fail;
  } queue_result_t;

  class msg_queue_sb;
    logic [31:0] handle_mem[DEPTH];
    logic [7:0]  type_mem[DEPTH];
    logic [15:0] recv_mem[DEPTH];
    int link[DEPTH];
    int head[NLVL];
    int tail[NLVL];
    int count[NLVL];
    int free_top;
    int taken;
    logic [31:0] dropped, enq_fail, deq_fail;
    int limit;
    bit drop_mode;
    queue_result_t expected_results[$];
    int errors;

    function new();
      errors = 0;
      limit = 0;
      drop_mode = 0;
      free_top = 0;
      taken = 0;
      dropped = 0;
      enq_fail = 0;
      deq_fail = 0;
      for (int l = 0; l < NLVL; l++) begin
        head[l] = 0;
        tail[l] = 0;
        count[l] = 0;
      end
    endfunction

    function int held();
      held = count[0] + count[1] + count[2] + count[3];
    endfunction

    function void note_input(logic [1:0] cmd, logic [31:0] hnd, logic [2:0] prio,
                             logic [7:0] typ, logic [15:0] recv);
      queue_result_t r;
      int n, lvl, e, cur, prv, nx;
      bit has_prv, found, hit;
      r = '0;
      n = held();
      if (cmd == flpmq_pkg::CMD_ENQ) begin
        if (hnd == 0) begin
          r.status = flpmq_pkg::ST_REFUSED;
          enq_fail++;
        end else if (limit != 0 && n >= limit) begin
          if (drop_mode) begin
            r.status = flpmq_pkg::ST_DROPPED;
            dropped++;
          end else begin
            r.status = flpmq_pkg::ST_REFUSED;
            enq_fail++;
          end
        end else if (n >= DEPTH) begin
          r.status = flpmq_pkg::ST_REFUSED;
          enq_fail++;
        end else begin
          lvl = (prio >= NLVL) ? 2 : prio;
          if (taken > n) begin
            e = free_top;
            free_top = link[e];
          end else begin
            e = taken;
            taken++;
          end
          handle_mem[e] = hnd;
          type_mem[e] = typ;
          recv_mem[e] = recv;
          link[e] = 0;
          if (count[lvl] == 0) head[lvl] = e;
          else link[tail[lvl]] = e;
          tail[lvl] = e;
          count[lvl]++;
        end
      end else begin
        found = 0;
        for (int l = NLVL - 1; l >= 0 && !found; l--) begin
          cur = head[l];
          prv = 0;
          has_prv = 0;
          for (int k = 0; k < count[l] && !found; k++) begin
            if (cmd == flpmq_pkg::CMD_DEQ) hit = 1;
            else if (cmd == flpmq_pkg::CMD_DEQ_TYPE) hit = (type_mem[cur] == typ);
            else hit = (recv_mem[cur] == recv) ||
                       (recv_mem[cur] == flpmq_pkg::RECV_BROADCAST);
            if (hit) begin
              nx = link[cur];
              if (!has_prv) head[l] = nx;
              else link[prv] = nx;
              if (cur == tail[l] && has_prv) tail[l] = prv;
              count[l]--;
              r.handle = handle_mem[cur];
              r.level = 2'(l);
              r.typ = type_mem[cur];
              r.recv = recv_mem[cur];
              link[cur] = free_top;
              free_top = cur;
              found = 1;
            end else begin
              prv = cur;
              has_prv = 1;
              cur = link[cur];
            end
          end
        end
        if (!found) begin
          r.status = flpmq_pkg::ST_EMPTY;
          if (cmd == flpmq_pkg::CMD_DEQ) deq_fail++;
        end
      end
      n = held();
      r.occupancy = 7'(n);
      r.at_limit = (limit != 0 && n >= limit);
      for (int l = NLVL - 1; l >= 0; l--) begin
        if (count[l] != 0 && !r.head_valid) begin
          r.head_valid = 1;
          r.head_handle = handle_mem[head[l]];
        end
      end
      r.dropped = dropped;
      r.enq_fail = enq_fail;
      r.deq_fail = deq_fail;
      expected_results.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      exp = expected_results.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic [31:0] in_msg_handle;
  logic [2:0] in_msg_priority;
  logic [7:0] in_msg_type;
  logic signed [15:0] in_msg_receiver;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic [31:0] out_out_handle;
  logic [1:0] out_out_priority;
  logic [7:0] out_out_type;
  logic signed [15:0] out_out_receiver;
  logic [6:0] out_occupancy;
  logic out_at_limit;
  logic out_head_valid;
  logic [31:0] out_head_handle;
  logic [31:0] out_dropped_total;
  logic [31:0] out_enqueue_fail_total;
  logic [31:0] out_dequeue_fail_total;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  msg_queue_sb sb = new();
  bit burst = 0;
  int cycles = 0;

  four_level_priority_message_queue_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_msg_handle(in_msg_handle), .in_msg_priority(in_msg_priority),
    .in_msg_type(in_msg_type), .in_msg_receiver(in_msg_receiver),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_out_handle(out_out_handle), .out_out_priority(out_out_priority),
    .out_out_type(out_out_type), .out_out_receiver(out_out_receiver),
    .out_occupancy(out_occupancy), .out_at_limit(out_at_limit),
    .out_head_valid(out_head_valid), .out_head_handle(out_head_handle),
    .out_dropped_total(out_dropped_total),
    .out_enqueue_fail_total(out_enqueue_fail_total),
    .out_dequeue_fail_total(out_dequeue_fail_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("four_level_priority_message_queue_unit regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SIZE_LIMIT) sb.limit = data[6:0];
    else sb.drop_mode = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(int limit, bit drop);
    wait_idle();
    cfg_write(ADDR_SIZE_LIMIT, 32'(limit));
    cfg_write(ADDR_DROP_MODE, {31'd0, drop});
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [31:0] hnd, logic [2:0] prio,
                          logic [7:0] typ, logic [15:0] recv);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_msg_handle <= hnd;
    in_msg_priority <= prio;
    in_msg_type <= typ;
    in_msg_receiver <= recv;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_input(cmd, hnd, prio, typ, recv);
  endtask

  task automatic send_random(int enq_pct);
    logic [1:0] cmd;
    logic [31:0] hnd;
    logic [7:0] typ;
    logic [15:0] recv;
    int pick;
    cmd = ($urandom_range(0, 99) < enq_pct) ? flpmq_pkg::CMD_ENQ
                                            : 2'($urandom_range(1, 3));
    hnd = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
    typ = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom());
    pick = $urandom_range(0, 3);
    if (pick == 0) recv = flpmq_pkg::RECV_BROADCAST;
    else if (pick == 3) recv = 16'($urandom());
    else recv = 16'($urandom_range(0, 5));
    send_cmd(cmd, hnd, 3'($urandom_range(0, 7)), typ, recv);
  endtask

  initial begin
    queue_result_t got;
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_status, out_out_handle, out_out_priority, out_out_type,
              out_out_receiver, out_occupancy, out_at_limit, out_head_valid,
              out_head_handle, out_dropped_total, out_enqueue_fail_total,
              out_dequeue_fail_total};
      sb.check_result(got);
    end
  end

  initial begin
    int limits[6] = '{0, 64, 5, 1, 37, 0};
    bit drops[6] = '{0, 1, 1, 0, 0, 1};
    int enq_pcts[6] = '{75, 60, 55, 50, 45, 40};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = flpmq_pkg::CMD_ENQ;
    in_msg_handle = '0;
    in_msg_priority = '0;
    in_msg_type = '0;
    in_msg_receiver = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_mode(0, 0);

    send_cmd(flpmq_pkg::CMD_DEQ, 32'd0, 3'd0, 8'd0, 16'd0);
    send_cmd(flpmq_pkg::CMD_DEQ_TYPE, 32'd0, 3'd0, 8'd0, 16'd0);
    send_cmd(flpmq_pkg::CMD_DEQ_RECV, 32'd0, 3'd0, 8'd0, flpmq_pkg::RECV_BROADCAST);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'd0, 3'd3, 8'd1, 16'd1);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 3'd7, 8'hFF, flpmq_pkg::RECV_BROADCAST);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'd1, 3'd0, 8'd0, 16'd0);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'h8000_0000, 3'd3, 8'h80, 16'h7FFF);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'h1234_5678, 3'd1, 8'd5, 16'd5);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'h0000_0004, 3'd4, 8'd6, 16'd6);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'h0000_0005, 3'd5, 8'd7, 16'd7);
    send_cmd(flpmq_pkg::CMD_DEQ_TYPE, 32'd0, 3'd0, 8'hFF, 16'd0);
    send_cmd(flpmq_pkg::CMD_DEQ_TYPE, 32'd0, 3'd0, 8'd99, 16'd0);
    send_cmd(flpmq_pkg::CMD_DEQ_RECV, 32'd0, 3'd0, 8'd0, 16'd9);
    send_cmd(flpmq_pkg::CMD_DEQ_RECV, 32'd0, 3'd0, 8'd0, flpmq_pkg::RECV_BROADCAST);
    send_cmd(flpmq_pkg::CMD_DEQ_RECV, 32'd0, 3'd0, 8'd0, 16'd6);
    send_cmd(flpmq_pkg::CMD_DEQ, 32'd0, 3'd0, 8'd0, 16'd0);
    set_mode(2, 1);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'd11, 3'd6, 8'd1, 16'd1);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'd12, 3'd2, 8'd2, 16'd2);
    set_mode(2, 0);
    send_cmd(flpmq_pkg::CMD_ENQ, 32'd13, 3'd1, 8'd3, 16'd3);
    repeat (4) send_cmd(flpmq_pkg::CMD_DEQ, 32'd0, 3'd0, 8'd0, 16'd0);

    for (int p = 0; p < 6; p++) begin
      set_mode(limits[p], drops[p]);
      for (int i = 0; i < 275; i++) begin
        if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_random(enq_pcts[p]);
      end
      burst = 0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("four_level_priority_message_queue_unit regression: pass");
    end else begin
      $display("four_level_priority_message_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
